// ----- rtl/binary_morphology_filter_core_macros.svh -----
// Assertion macros for the binary morphology filter core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BINARY_MORPHOLOGY_FILTER_CORE_MACROS_SVH
`define BINARY_MORPHOLOGY_FILTER_CORE_MACROS_SVH

// Property checked at every edge outside reset.
`define BMF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmf assertion failed");

// Condition in one cycle implies a condition in the next.
`define BMF_ASSERT_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("bmf assertion failed");

`endif

// ----- rtl/bmf_pkg.sv -----
// Package for the binary morphology filter: payload types, codes, constants.
// Also holds the structuring element mask function. No dependencies.
`timescale 1ns / 1ps

package bmf_pkg;

	localparam int BMF_MAX_IMAGE_WIDTH = 1024;
	localparam int BMF_MAX_KERNEL_SIZE = 15;
	localparam int CFG_W               = 11;
	localparam int CFG_IDX_W           = 3;
	localparam int ROW_W               = 12;
	localparam int FIFO_DEPTH          = 16;

	localparam logic [2:0] MODE_DILATE   = 3'd0;
	localparam logic [2:0] MODE_ERODE    = 3'd1;
	localparam logic [2:0] MODE_CLOSE    = 3'd2;
	localparam logic [2:0] MODE_OPEN     = 3'd3;
	localparam logic [2:0] MODE_GRADIENT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KER_W  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KER_H  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 3'd5;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       is_pad;
	} in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_end;
	} out_t;

	// Membership of window tap (row j, column m) in the structuring element.
	function automatic logic ker_bit(input logic [4:0] hw, input logic [4:0] hh,
			input logic [4:0] m, input logic [4:0] j, input logic ell);
		logic [4:0]  dc;
		logic [4:0]  dr;
		logic [5:0]  kw;
		logic [5:0]  kh;
		logic [9:0]  w2;
		logic [9:0]  h2;
		logic [9:0]  ui;
		logic [9:0]  uj;
		logic [19:0] lhs;
		logic [19:0] rhs;
		logic        hit;
		dc  = (m > hw) ? (m - hw) : (hw - m);
		dr  = (j > hh) ? (j - hh) : (hh - j);
		kw  = {hw, 1'b1};
		kh  = {hh, 1'b1};
		w2  = 10'((12'(kw) * 12'(kw)) >> 2);
		h2  = 10'((12'(kh) * 12'(kh)) >> 2);
		ui  = 10'(dc) * 10'(dc);
		uj  = 10'(dr) * 10'(dr);
		lhs = 20'(ui) * 20'(h2) + 20'(uj) * 20'(w2);
		rhs = 20'(w2) * 20'(h2);
		hit = (6'(m) <= {hw, 1'b0}) && (6'(j) <= {hh, 1'b0});
		if (ell && (lhs > rhs)) begin
			hit = 1'b0;
		end
		return hit;
	endfunction

endpackage

// ----- rtl/bmf_window.sv -----
// Line buffer, sliding window and masked dilate/erode evaluation for one stage.
// Depends on bmf_pkg. The line buffer read, the window and the result are registered in turn.
`timescale 1ns / 1ps

module bmf_window
	import bmf_pkg::*;
#(
	parameter int MAX_IMAGE_WIDTH = BMF_MAX_IMAGE_WIDTH,
	parameter int MAX_KERNEL_SIZE = BMF_MAX_KERNEL_SIZE,
	localparam int CW   = $clog2(MAX_IMAGE_WIDTH),
	localparam int WW   = $clog2(MAX_IMAGE_WIDTH + 1),
	localparam int HB   = $clog2((MAX_KERNEL_SIZE - 1) / 2 + 1),
	localparam int KK   = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 bit_in,
	input  logic [CW-1:0]        col,
	input  logic [ROW_W-1:0]     crow,
	input  logic [CW-1:0]        ccol,
	input  logic [WW-1:0]        img_w,
	input  logic [CFG_W-1:0]     img_h,
	input  logic [HB-1:0]        half_w,
	input  logic [HB-1:0]        half_h,
	input  logic [KK-1:0]        ker,
	output logic                 dil,
	output logic                 ero
);

	logic [MAX_KERNEL_SIZE-2:0] mem [MAX_IMAGE_WIDTH];

	logic                       push_s1;
	logic                       bit_s1;
	logic [CW-1:0]              col_s1;
	logic [ROW_W-1:0]           crow_s1;
	logic [CW-1:0]              ccol_s1;
	logic [MAX_KERNEL_SIZE-2:0] rd_s1;
	logic [MAX_KERNEL_SIZE-2:0] wr_vec;

	logic [MAX_KERNEL_SIZE-1:0] win_q [MAX_KERNEL_SIZE];
	logic [MAX_KERNEL_SIZE-1:0] rv_c;
	logic [MAX_KERNEL_SIZE-1:0] cv_c;
	logic [MAX_KERNEL_SIZE-1:0] rv_s2;
	logic [MAX_KERNEL_SIZE-1:0] cv_s2;
	logic                       any_c;
	logic                       all_c;
	logic                       dil_q;
	logic                       ero_q;
	logic [ROW_W:0]             rs;
	logic [WW:0]                cs;

	assign wr_vec = {rd_s1[MAX_KERNEL_SIZE-3:0], bit_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
		end else begin
			push_s1 <= push;
		end
	end

	// read with bypass of the write going out at the same edge
	always_ff @(posedge clk) begin
		if (push_s1) begin
			mem[col_s1] <= wr_vec;
		end
		if (push) begin
			rd_s1 <= (push_s1 && (col_s1 == col)) ? wr_vec : mem[col];
		end
		bit_s1  <= bit_in;
		col_s1  <= col;
		crow_s1 <= crow;
		ccol_s1 <= ccol;
	end

	always_comb begin
		rs = (ROW_W + 1)'(crow_s1) + (ROW_W + 1)'(half_h);
		cs = (WW + 1)'(ccol_s1) + (WW + 1)'(half_w);
		for (int j = 0; j < MAX_KERNEL_SIZE; j++) begin
			rv_c[j] = ((ROW_W + 1)'(j) <= (ROW_W + 1)'({half_h, 1'b0})) &&
				(rs >= (ROW_W + 1)'(j)) &&
				((ROW_W + 2)'(rs) < (ROW_W + 2)'(img_h) + (ROW_W + 2)'(j));
			cv_c[j] = ((WW + 1)'(j) <= (WW + 1)'({half_w, 1'b0})) &&
				(cs >= (WW + 1)'(j)) &&
				((WW + 2)'(cs) < (WW + 2)'(img_w) + (WW + 2)'(j));
		end
	end

	always_ff @(posedge clk) begin
		rv_s2 <= rv_c;
		cv_s2 <= cv_c;
		if (push_s1) begin
			win_q[0] <= {rd_s1, bit_s1};
			for (int m = 1; m < MAX_KERNEL_SIZE; m++) begin
				win_q[m] <= win_q[m-1];
			end
		end
	end

	always_comb begin
		logic hit;
		any_c = 1'b0;
		all_c = 1'b1;
		for (int j = 0; j < MAX_KERNEL_SIZE; j++) begin
			for (int m = 0; m < MAX_KERNEL_SIZE; m++) begin
				hit   = rv_s2[j] & cv_s2[m] & ker[j*MAX_KERNEL_SIZE+m];
				any_c = any_c | (hit & win_q[m][j]);
				all_c = all_c & (~hit | win_q[m][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		dil_q <= any_c;
		ero_q <= all_c;
	end

	assign dil = dil_q;
	assign ero = ero_q;

endmodule

// ----- rtl/binary_morphology_filter_core.sv -----
// Top level of the binary morphology filter: configuration, stream control,
// two window stages and the output queue. Depends on bmf_pkg, bmf_window
// and binary_morphology_filter_core_macros.svh.
//
// Usage:
//  in_valid/in_stall/in_data carry raster-order pixels; is_pad items push
//  out the delayed rows after the last pixel of a frame. out_valid/out_stall/
//  out_data carry 0 or 255 pixels, frame_end on the last of a frame.
//  cfg_we/cfg_index/cfg_data write the registers; write only while idle.
//  Throughput: one transaction per clock on both channels while neither stalls.
//  Latency: after the transaction that completes its window, a result passes
//  aux_s1 to aux_s6 and the output queue, the same for every mode; the window
//  delay in transactions is hh*W+hw (twice that for open and close).
//  in_stall is held after reset and after a register write while geometry and
//  mask are rebuilt, and when the 16-entry output queue plus the transactions
//  in flight fill it. A stalled receiver lets up to 16 results collect before
//  the input stalls.
//  Reset restores the register defaults and starts a new frame; line buffer
//  contents are never cleared since taps outside the image are masked.
`timescale 1ns / 1ps
`include "binary_morphology_filter_core_macros.svh"

module binary_morphology_filter_core
	import bmf_pkg::*;
#(
	parameter int MAX_IMAGE_WIDTH = BMF_MAX_IMAGE_WIDTH,
	parameter int MAX_KERNEL_SIZE = BMF_MAX_KERNEL_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW    = $clog2(MAX_IMAGE_WIDTH);
	localparam int WW    = $clog2(MAX_IMAGE_WIDTH + 1);
	localparam int HMAX  = (MAX_KERNEL_SIZE - 1) / 2;
	localparam int WLIM  = (MAX_KERNEL_SIZE < MAX_IMAGE_WIDTH) ? MAX_KERNEL_SIZE
		: MAX_IMAGE_WIDTH;
	localparam int HMAXW = (WLIM - 1) / 2;
	localparam int HB    = $clog2(HMAX + 1);
	localparam int KK    = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
	localparam int PW    = WW + CFG_W + 2;
	localparam int FPW   = $clog2(FIFO_DEPTH);
	localparam int OCW   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic             valid;
		logic             push_b;
		logic [CW-1:0]    bcol;
		logic [ROW_W-1:0] brow;
		logic [CW-1:0]    bccol;
		logic             emit;
		logic             fend;
		logic [2:0]       mode;
		logic             gedge;
		logic             res;
	} aux_t;

	// configuration registers
	logic [2:0]       mode_q;
	logic             shape_q;
	logic [3:0]       kw_q;
	logic [3:0]       kh_q;
	logic [CFG_W-1:0] iw_q;
	logic [CFG_W-1:0] ih_q;
	logic [1:0]       cfg_wait_q;

	// derived geometry
	logic [WW-1:0]    w_c, w_q;
	logic [CFG_W-1:0] h_c, h_q;
	logic [HB-1:0]    hw_c, hw_q, hh_c, hh_q;
	logic [PW-1:0]    n_q, d_c, d_q, lag_q, d2_q;
	logic [3:0]       kwm, khm;
	logic [KK-1:0]    ker_c, ker_q;

	// stream position
	logic [PW-1:0]    p_q, out_q, ep, eo;
	logic [CW-1:0]    pcol_q, acol_q, bcol_q, epcol, eacol, ebcol;
	logic [ROW_W-1:0] arow_q, brow_q, earow, ebrow;

	logic             in_acc, start, consume, pa_ok, pb_ok, emit, fend, gedge;
	logic             two_c;
	logic             bit_a;
	logic             dil_a, ero_a, dil_b, ero_b;
	logic             push_b_in, bit_b, res1_c, res_f;
	aux_t             aux_c, aux_r, aux_s1, aux_s2, aux_s3, aux_s4, aux_s5, aux_s6;

	// output queue
	out_t             fifo_q [FIFO_DEPTH];
	logic [FPW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OCW-1:0]   fifo_cnt_q, occ_q;
	logic             fifo_push, pop, take, drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_DILATE;
			shape_q    <= 1'b0;
			kw_q       <= 4'd3;
			kh_q       <= 4'd3;
			iw_q       <= 11'd640;
			ih_q       <= 11'd480;
			cfg_wait_q <= 2'd3;
		end else begin
			if (cfg_we) begin
				cfg_wait_q <= 2'd3;
				unique case (cfg_index)
					CFG_MODE:  mode_q  <= cfg_data[2:0];
					CFG_SHAPE: shape_q <= cfg_data[0];
					CFG_KER_W: kw_q    <= cfg_data[3:0];
					CFG_KER_H: kh_q    <= cfg_data[3:0];
					CFG_IMG_W: iw_q    <= cfg_data;
					CFG_IMG_H: ih_q    <= cfg_data;
					default: ;
				endcase
			end else if (cfg_wait_q != 2'd0) begin
				cfg_wait_q <= cfg_wait_q - 2'd1;
			end
		end
	end

	always_comb begin
		if (iw_q == '0) begin
			w_c = WW'(1);
		end else if (int'(iw_q) > MAX_IMAGE_WIDTH) begin
			w_c = WW'(MAX_IMAGE_WIDTH);
		end else begin
			w_c = WW'(iw_q);
		end
		h_c = (ih_q == '0) ? CFG_W'(1) : ih_q;
		kwm = (kw_q == 4'd0) ? 4'd0 : ((kw_q - 4'd1) >> 1);
		khm = (kh_q == 4'd0) ? 4'd0 : ((kh_q - 4'd1) >> 1);
		hw_c = (int'(kwm) > HMAXW) ? HB'(HMAXW) : HB'(kwm);
		hh_c = (int'(khm) > HMAX) ? HB'(HMAX) : HB'(khm);
		d_c  = PW'(hh_c) * PW'(w_c) + PW'(hw_c);
		two_c = (mode_q == MODE_CLOSE) || (mode_q == MODE_OPEN);
	end

	always_comb begin
		for (int j = 0; j < MAX_KERNEL_SIZE; j++) begin
			for (int m = 0; m < MAX_KERNEL_SIZE; m++) begin
				ker_c[j*MAX_KERNEL_SIZE+m] = ker_bit(5'(hw_q), 5'(hh_q), 5'(m), 5'(j), shape_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		w_q   <= w_c;
		h_q   <= h_c;
		hw_q  <= hw_c;
		hh_q  <= hh_c;
		n_q   <= PW'(w_c) * PW'(h_c);
		d_q   <= d_c;
		d2_q  <= d_c << 1;
		lag_q <= two_c ? (d_c << 1) : d_c;
		ker_q <= ker_c;
	end

	assign in_stall = (occ_q >= OCW'(FIFO_DEPTH)) || (cfg_wait_q != 2'd0);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		start   = out_q >= n_q;
		ep      = start ? '0 : p_q;
		eo      = start ? '0 : out_q;
		epcol   = start ? '0 : pcol_q;
		eacol   = start ? '0 : acol_q;
		earow   = start ? '0 : arow_q;
		ebcol   = start ? '0 : bcol_q;
		ebrow   = start ? '0 : brow_q;
		consume = !((ep < n_q) && in_data.is_pad);
		pa_ok   = ep >= d_q;
		pb_ok   = ep >= d2_q;
		emit    = (PW + 1)'(ep) >= (PW + 1)'(eo) + (PW + 1)'(lag_q);
		fend    = emit && ((PW + 1)'(eo) + (PW + 1)'(1) >= (PW + 1)'(n_q));
		gedge   = ((WW)'(eacol) <= WW'(hw_q)) || ((w_q - WW'(1) - WW'(eacol)) <= WW'(hw_q));
		bit_a   = (ep < n_q) && (in_data.pixel_in != 8'd0);
		take    = in_acc && consume;

		aux_c.valid  = take;
		aux_c.push_b = two_c && pa_ok;
		aux_c.bcol   = eacol;
		aux_c.brow   = ebrow;
		aux_c.bccol  = ebcol;
		aux_c.emit   = emit;
		aux_c.fend   = fend;
		aux_c.mode   = mode_q;
		aux_c.gedge  = gedge;
		aux_c.res    = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			out_q  <= '0;
			pcol_q <= '0;
			acol_q <= '0;
			arow_q <= '0;
			bcol_q <= '0;
			brow_q <= '0;
		end else if (in_acc) begin
			if (!consume || fend) begin
				p_q    <= consume ? '0 : ep;
				out_q  <= consume ? '0 : eo;
				pcol_q <= consume ? '0 : epcol;
				acol_q <= consume ? '0 : eacol;
				arow_q <= consume ? '0 : earow;
				bcol_q <= consume ? '0 : ebcol;
				brow_q <= consume ? '0 : ebrow;
			end else begin
				p_q    <= ep + PW'(1);
				pcol_q <= (WW'(epcol) == w_q - WW'(1)) ? '0 : epcol + CW'(1);
				out_q  <= emit ? eo + PW'(1) : eo;
				acol_q <= eacol;
				arow_q <= earow;
				bcol_q <= ebcol;
				brow_q <= ebrow;
				if (pa_ok) begin
					if (WW'(eacol) == w_q - WW'(1)) begin
						acol_q <= '0;
						arow_q <= earow + ROW_W'(1);
					end else begin
						acol_q <= eacol + CW'(1);
					end
				end
				if (pb_ok) begin
					if (WW'(ebcol) == w_q - WW'(1)) begin
						bcol_q <= '0;
						brow_q <= ebrow + ROW_W'(1);
					end else begin
						bcol_q <= ebcol + CW'(1);
					end
				end
			end
		end
	end

	bmf_window #(
		.MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
		.MAX_KERNEL_SIZE(MAX_KERNEL_SIZE)
	) u_stage_a (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.bit_in (bit_a),
		.col    (epcol),
		.crow   (earow),
		.ccol   (eacol),
		.img_w  (w_q),
		.img_h  (h_q),
		.half_w (hw_q),
		.half_h (hh_q),
		.ker    (ker_q),
		.dil    (dil_a),
		.ero    (ero_a)
	);

	always_comb begin
		unique case (aux_s3.mode)
			MODE_ERODE:    res1_c = ero_a;
			MODE_GRADIENT: res1_c = !aux_s3.gedge && dil_a && !ero_a;
			default:       res1_c = dil_a;
		endcase
		push_b_in = aux_s3.valid && aux_s3.push_b;
		bit_b     = (aux_s3.mode == MODE_OPEN) ? ero_a : dil_a;
		aux_r     = aux_s3;
		aux_r.res = res1_c;
	end

	bmf_window #(
		.MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
		.MAX_KERNEL_SIZE(MAX_KERNEL_SIZE)
	) u_stage_b (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_b_in),
		.bit_in (bit_b),
		.col    (aux_s3.bcol),
		.crow   (aux_s3.brow),
		.ccol   (aux_s3.bccol),
		.img_w  (w_q),
		.img_h  (h_q),
		.half_w (hw_q),
		.half_h (hh_q),
		.ker    (ker_q),
		.dil    (dil_b),
		.ero    (ero_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aux_s1 <= '0;
			aux_s2 <= '0;
			aux_s3 <= '0;
			aux_s4 <= '0;
			aux_s5 <= '0;
			aux_s6 <= '0;
		end else begin
			aux_s1 <= aux_c;
			aux_s2 <= aux_s1;
			aux_s3 <= aux_s2;
			aux_s4 <= aux_r;
			aux_s5 <= aux_s4;
			aux_s6 <= aux_s5;
		end
	end

	always_comb begin
		unique case (aux_s6.mode)
			MODE_CLOSE: res_f = ero_b;
			MODE_OPEN:  res_f = dil_b;
			default:    res_f = aux_s6.res;
		endcase
		fifo_push = aux_s6.valid && aux_s6.emit;
		drop      = aux_s6.valid && !aux_s6.emit;
		pop       = out_valid && !out_stall;
	end

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_q[wr_ptr_q].pixel_out <= res_f ? 8'd255 : 8'd0;
			fifo_q[wr_ptr_q].frame_end <= aux_s6.fend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			occ_q      <= '0;
		end else begin
			if (fifo_push) begin
				wr_ptr_q <= wr_ptr_q + FPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FPW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + OCW'(fifo_push) - OCW'(pop);
			occ_q      <= occ_q + OCW'(take) - OCW'(pop) - OCW'(drop);
		end
	end

	assign out_valid = fifo_cnt_q != '0;
	assign out_data  = fifo_q[rd_ptr_q];

	`BMF_ASSERT(a_fifo_room, fifo_push |-> (fifo_cnt_q < OCW'(FIFO_DEPTH)))
	`BMF_ASSERT(a_credit_cover, occ_q >= fifo_cnt_q)
	`BMF_ASSERT_NEXT(a_cfg_holds_input, cfg_we, in_stall)

endmodule

// ----- test/tb_binary_morphology_filter_core.sv -----
// Testbench for binary_morphology_filter_core: directed frames from a table, then random
// frames, each checked against a behavioral predictor of the filter. Depends on bmf_pkg.
`timescale 1ns / 1ps

module tb_binary_morphology_filter_core;
	import bmf_pkg::*;

	localparam int LINE_DEPTH = BMF_MAX_KERNEL_SIZE * BMF_MAX_IMAGE_WIDTH;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PAT_RANDOM = 0;
	localparam int PAT_ZERO = 1;
	localparam int PAT_HIGH = 2;
	localparam int PAT_DOT = 3;

	typedef struct {
		int mode, shape, kw, kh, w, h, pattern;
		bit typed;
		int pix;
	} frame_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	binary_morphology_filter_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	bit [2:0]    op_mode;
	bit          ker_ellipse;
	bit [3:0]    ker_w, ker_h;
	bit [10:0]   img_w, img_h;
	bit          first_lines [LINE_DEPTH];
	bit          second_lines [LINE_DEPTH];
	int unsigned in_pos, out_pos;
	int unsigned gw, gh, ghw, ghh, gkw, gkh;
	bit          frame_done;
	bit          typed_on;
	bit [7:0]    typed_pix;
	out_t        expected_pixels[$];

	int  fails;
	int  cycles;
	int  phase;
	int  rand_items;

	frame_row_t directed_frames[] = '{
		'{0, 0, 3, 3, 5, 4, PAT_ZERO, 1, 0},
		'{1, 0, 3, 3, 5, 4, PAT_HIGH, 1, 255},
		'{2, 0, 3, 3, 5, 4, PAT_RANDOM, 0, 0},
		'{3, 0, 3, 3, 5, 4, PAT_RANDOM, 0, 0},
		'{4, 0, 3, 3, 5, 4, PAT_RANDOM, 0, 0},
		'{4, 0, 5, 5, 4, 4, PAT_RANDOM, 1, 0},
		'{0, 1, 7, 5, 9, 6, PAT_DOT, 0, 0},
		'{1, 1, 15, 15, 16, 4, PAT_RANDOM, 0, 0},
		'{7, 0, 3, 3, 6, 5, PAT_RANDOM, 0, 0},
		'{5, 0, 0, 0, 5, 5, PAT_RANDOM, 0, 0},
		'{2, 0, 4, 2, 7, 5, PAT_RANDOM, 0, 0},
		'{3, 1, 15, 15, 16, 5, PAT_RANDOM, 0, 0},
		'{0, 0, 15, 15, 17, 1, PAT_RANDOM, 0, 0},
		'{1, 0, 3, 3, 0, 0, PAT_HIGH, 1, 255},
		'{4, 0, 1, 15, 1, 16, PAT_RANDOM, 1, 0},
		'{1, 0, 3, 3, 7, 0, PAT_RANDOM, 0, 0},
		'{6, 1, 9, 15, 1, 20, PAT_RANDOM, 0, 0}
	};

	function automatic void refresh_geometry();
		gw  = (img_w == 0) ? 1 : img_w;
		if (gw > BMF_MAX_IMAGE_WIDTH) begin
			gw = BMF_MAX_IMAGE_WIDTH;
		end
		gh  = (img_h == 0) ? 1 : img_h;
		ghw = (ker_w >= 1) ? (ker_w - 1) / 2 : 0;
		ghh = (ker_h >= 1) ? (ker_h - 1) / 2 : 0;
		if (ghw > (BMF_MAX_KERNEL_SIZE - 1) / 2) begin
			ghw = (BMF_MAX_KERNEL_SIZE - 1) / 2;
		end
		if (ghh > (BMF_MAX_KERNEL_SIZE - 1) / 2) begin
			ghh = (BMF_MAX_KERNEL_SIZE - 1) / 2;
		end
		gkw = 2 * ghw + 1;
		gkh = 2 * ghh + 1;
	endfunction

	// all_high 0: any in-image neighbor high; 1: every in-image neighbor high
	function automatic bit window_result(bit from_second, int unsigned k, bit all_high);
		int          r, c, dr, dc, rr, cc;
		int unsigned w2, h2, ui, uj, idx;
		bit          v;
		r  = k / gw;
		c  = k % gw;
		w2 = gkw * gkw / 4;
		h2 = gkh * gkh / 4;
		for (dr = -int'(ghh); dr <= int'(ghh); dr++) begin
			for (dc = -int'(ghw); dc <= int'(ghw); dc++) begin
				rr = r + dr;
				cc = c + dc;
				ui = dc * dc;
				uj = dr * dr;
				if (ker_ellipse && ui * h2 + uj * w2 > w2 * h2) continue;
				if (rr < 0 || cc < 0 || rr >= int'(gh) || cc >= int'(gw)) continue;
				idx = (rr * gw + cc) % LINE_DEPTH;
				v = from_second ? second_lines[idx] : first_lines[idx];
				if (all_high && !v) return 1'b0;
				if (!all_high && v) return 1'b1;
			end
		end
		return all_high;
	endfunction

	function automatic void predict_pixel(in_t d);
		int unsigned n, dly, lag, t, k, j, c;
		bit          two_stage, res;
		out_t        e;
		refresh_geometry();
		n = gw * gh;
		two_stage = (op_mode == MODE_CLOSE) || (op_mode == MODE_OPEN);
		dly = ghh * gw + ghw;
		lag = two_stage ? 2 * dly : dly;
		if (out_pos >= n) begin
			in_pos = 0;
			out_pos = 0;
		end
		if (in_pos < n) begin
			if (d.is_pad) return;
			first_lines[in_pos % LINE_DEPTH] = (d.pixel_in != 0);
		end
		in_pos++;
		t = in_pos;
		if (two_stage && t - 1 >= dly && t - 1 - dly < n) begin
			j = t - 1 - dly;
			second_lines[j % LINE_DEPTH] = window_result(1'b0, j, op_mode == MODE_OPEN);
		end
		if (t <= out_pos + lag) return;
		k = out_pos;
		case (op_mode)
			MODE_ERODE: res = window_result(1'b0, k, 1'b1);
			MODE_CLOSE: res = window_result(1'b1, k, 1'b1);
			MODE_OPEN:  res = window_result(1'b1, k, 1'b0);
			MODE_GRADIENT: begin
				c = k % gw;
				if (2 * c < gkw || 2 * (gw - 1 - c) < gkw)
					res = 1'b0;
				else
					res = window_result(1'b0, k, 1'b0) && !window_result(1'b0, k, 1'b1);
			end
			default: res = window_result(1'b0, k, 1'b0);
		endcase
		out_pos++;
		e.pixel_out = res ? 8'd255 : 8'd0;
		e.frame_end = 1'b0;
		if (out_pos >= n) begin
			e.frame_end = 1'b1;
			in_pos = 0;
			out_pos = 0;
			frame_done = 1'b1;
		end
		if (typed_on) begin
			e.pixel_out = typed_pix;
		end
		expected_pixels.push_back(e);
	endfunction

	task automatic send_item(in_t d);
		int idle_pct;
		idle_pct = (phase == 0) ? 23 : (phase == 1) ? 81 : 0;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (in_stall);
		predict_pixel(d);
		rand_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODE:  op_mode = 3'(value);
			CFG_SHAPE: ker_ellipse = value[0];
			CFG_KER_W: ker_w = 4'(value);
			CFG_KER_H: ker_h = 4'(value);
			CFG_IMG_W: img_w = 11'(value);
			CFG_IMG_H: img_h = 11'(value);
			default: ;
		endcase
	endtask

	task automatic run_frame(frame_row_t row, bit noisy, bit hold_mid);
		int unsigned n, i;
		in_t         d;
		wait_drained();
		repeat (16) @(posedge clk);
		write_reg(CFG_MODE, row.mode);
		write_reg(CFG_SHAPE, row.shape);
		write_reg(CFG_KER_W, row.kw);
		write_reg(CFG_KER_H, row.kh);
		write_reg(CFG_IMG_W, row.w);
		write_reg(CFG_IMG_H, row.h);
		refresh_geometry();
		n = gw * gh;
		typed_on = row.typed;
		typed_pix = 8'(row.pix);
		frame_done = 1'b0;
		for (i = 0; i < n; i++) begin
			if (noisy && $urandom_range(19) == 0) begin
				d.pixel_in = 8'($urandom);
				d.is_pad = 1'b1;
				send_item(d);
			end
			if (hold_mid && i == n / 2) begin
				wait_drained();
			end
			d.is_pad = 1'b0;
			case (row.pattern)
				PAT_ZERO: d.pixel_in = 8'd0;
				PAT_HIGH: d.pixel_in = 8'($urandom_range(1, 255));
				PAT_DOT:  d.pixel_in = (i == n / 2 + gw / 2) ? 8'hff : 8'h00;
				default:  d.pixel_in = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
			endcase
			send_item(d);
		end
		while (!frame_done) begin
			d.pixel_in = 8'($urandom);
			d.is_pad = !(noisy && $urandom_range(9) == 0);
			send_item(d);
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		out_stall <= $urandom_range(99) < ((phase == 0) ? 81 : (phase == 1) ? 23 : 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
				fails++;
			end else begin
				if (out_data.pixel_out !== expected_pixels[0].pixel_out) begin
					$display("%0t: pixel_out expected %0d actual %0d", $time,
						expected_pixels[0].pixel_out, out_data.pixel_out);
					fails++;
				end
				if (out_data.frame_end !== expected_pixels[0].frame_end) begin
					$display("%0t: frame_end expected %0d actual %0d", $time,
						expected_pixels[0].frame_end, out_data.frame_end);
					fails++;
				end
				void'(expected_pixels.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		frame_row_t r;
		int         i, settle;
		fails = 0;
		cycles = 0;
		phase = 0;
		rand_items = 0;
		op_mode = MODE_DILATE;
		ker_ellipse = 1'b0;
		ker_w = 4'd3;
		ker_h = 4'd3;
		img_w = 11'd640;
		img_h = 11'd480;
		in_pos = 0;
		out_pos = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		out_stall <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < directed_frames.size(); i++) begin
			run_frame(directed_frames[i], i == 2, i == 3);
		end
		rand_items = 0;
		while (rand_items < 100) begin
			phase = (rand_items < 35) ? 0 : (rand_items < 70) ? 1 : 2;
			r.mode = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			r.shape = $urandom_range(1);
			r.kw = $urandom_range(0, 15);
			r.kh = $urandom_range(0, 7);
			r.w = $urandom_range(1, 12);
			r.h = $urandom_range(1, 10);
			r.pattern = PAT_RANDOM;
			r.typed = 1'b0;
			r.pix = 0;
			run_frame(r, $urandom_range(3) == 0, 1'b0);
		end
		wait_drained();
		for (settle = 0; settle < 40; settle++) @(posedge clk);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_window.sv
rtl/binary_morphology_filter_core.sv
test/tb_binary_morphology_filter_core.sv
